/* rtl/pid_controller_anti_windup_defines.svh */
// Assertion macros for the PID controller block.
// Included by the RTL files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDAW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDAW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pidaw_pkg.sv */
// Package for the PID controller with conditional-integration anti-windup.
// Holds widths, register indexes, reset values and the sequencer state type; no dependencies.
package pidaw_pkg;

    localparam int OUTPUT_MAX_DEF = 1023;
    localparam int SUM_WIDTH_DEF  = 32;

    localparam int SAMPLE_W    = 10;
    localparam int PERIOD_W    = 10;
    localparam int GAIN_W      = 15;
    localparam int DRIVE_W     = 10;
    localparam int ERR_W       = 11;
    localparam int DIFF_W      = 12;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    localparam int HALF_W    = 20;
    localparam int MAG_W     = 2 * HALF_W;
    localparam int MUL_A_W   = 25;
    localparam int MUL_P_W   = MUL_A_W + HALF_W;
    localparam int DIV_W     = 26;
    localparam int DIVCNT_W  = 5;
    localparam int TERM_W    = MUL_P_W + HALF_W + 1;
    localparam int ISAT_W    = 51;
    localparam int ACC_W     = 53;

    localparam logic [TERM_W-1:0] TERM_LIMIT = TERM_W'(64'd1 << 50);

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(10);
    localparam logic [GAIN_W-1:0]   KI_RST     = GAIN_W'(100);
    localparam logic [GAIN_W-1:0]   KP_RST     = GAIN_W'(1);
    localparam logic [GAIN_W-1:0]   KD_RST     = GAIN_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD = 2'd0,
        REG_KI     = 2'd1,
        REG_KP     = 2'd2,
        REG_KD     = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_KI,
        S_KD,
        S_ILO,
        S_IHI,
        S_IADD,
        S_ISAT,
        S_DIV,
        S_FIN,
        S_OUT
    } t_pid_state;

endpackage

/* rtl/pid_controller_anti_windup.sv */
// PID controller with conditional-integration anti-windup and a clamped 10-bit drive.
// Depends on pidaw_pkg and pid_controller_anti_windup_defines.svh.
//
// Each request carries a measured value and a setpoint and yields one drive value.
// A request runs from acceptance to the result register, and the next request is taken
// in the cycle after the result is loaded, so a new request waits until the last one is
// through, and longer while the output side does not keep up. The work is five
// passes through one shared 25x20 multiplier and a 26-step restoring divider for the
// derivative term. The input is not ready while a request is in work. Write the
// configuration registers only while the block is idle.
`include "pid_controller_anti_windup_defines.svh"

module pid_controller_anti_windup #(
    parameter int OUTPUT_MAX = pidaw_pkg::OUTPUT_MAX_DEF,
    parameter int SUM_WIDTH  = pidaw_pkg::SUM_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: measured[9:0], setpoint[19:10], zero fill.
    input  logic [pidaw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: drive[9:0], zero fill.
    output logic [pidaw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import pidaw_pkg::*;

    localparam logic signed [ACC_W-1:0] L_OUT_MAX = ACC_W'(OUTPUT_MAX);
    localparam logic signed [ACC_W-1:0] L_ZERO    = '0;
    localparam logic signed [SUM_WIDTH-1:0] L_SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] L_SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    t_pid_state r_state, n_state;

    logic [PERIOD_W-1:0] r_period;
    logic [GAIN_W-1:0]   r_ki, r_kp, r_kd;

    logic signed [ERR_W-1:0]     r_err, r_prev_err;
    logic signed [DIFF_W-1:0]    r_diff;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic                        r_int_ok;

    logic [MUL_P_W-1:0]  r_mul, r_ilo;
    logic [MUL_A_W-1:0]  r_gain;
    logic [MAG_W-1:0]    r_mag;
    logic                r_ineg;
    logic [TERM_W-1:0]   r_itot;
    logic signed [ACC_W-1:0] r_acc;

    logic [DIV_W-1:0]    r_dwork;
    logic [PERIOD_W-1:0] r_drem;
    logic [DIVCNT_W-1:0] r_dcnt;

    logic                r_out_valid;
    logic [DRIVE_W-1:0]  r_drive;

    logic [SAMPLE_W-1:0]       w_meas, w_setp;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [DIFF_W-1:0]  w_diff;
    logic                      w_accept, w_out_load;
    logic signed [SUM_WIDTH:0] w_sum_ext;
    logic signed [SUM_WIDTH-1:0] w_sum_sat;
    logic [ERR_W-1:0]          w_err_abs;
    logic [DIFF_W-1:0]         w_diff_abs;
    logic [SUM_WIDTH-1:0]      w_sum_abs;
    logic [MUL_A_W-1:0]        w_mul_a;
    logic [HALF_W-1:0]         w_mul_b;
    logic [MUL_P_W-1:0]        w_mul;
    logic signed [ACC_W-1:0]   w_kp_term, w_i_term, w_d_term;
    logic [ISAT_W-1:0]         w_isat;
    logic [PERIOD_W:0]         w_trial;
    logic                      w_qbit;
    logic [PERIOD_W-1:0]       w_rem;
    logic [DIV_W-1:0]          w_quot;
    logic signed [ACC_W-1:0]   w_y;

    assign w_meas   = s_axis_tdata[SAMPLE_W-1:0];
    assign w_setp   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign w_err    = $signed({1'b0, w_setp}) - $signed({1'b0, w_meas});
    assign w_diff   = $signed({w_err[ERR_W-1], w_err})
                    - $signed({r_prev_err[ERR_W-1], r_prev_err});
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-DRIVE_W){1'b0}}, r_drive};

    always_comb begin
        w_sum_ext = $signed({r_sum[SUM_WIDTH-1], r_sum})
                  + $signed({{(SUM_WIDTH+1-ERR_W){r_err[ERR_W-1]}}, r_err});
        if (w_sum_ext[SUM_WIDTH] != w_sum_ext[SUM_WIDTH-1]) begin
            w_sum_sat = w_sum_ext[SUM_WIDTH] ? L_SUM_MIN : L_SUM_MAX;
        end else begin
            w_sum_sat = w_sum_ext[SUM_WIDTH-1:0];
        end
    end

    assign w_err_abs  = r_err[ERR_W-1] ? (~r_err + 1'b1) : r_err;
    assign w_diff_abs = r_diff[DIFF_W-1] ? (~r_diff + 1'b1) : r_diff;
    assign w_sum_abs  = r_sum[SUM_WIDTH-1] ? (~r_sum + 1'b1) : r_sum;

    always_comb begin
        case (r_state)
            S_SUM: begin
                w_mul_a = MUL_A_W'(r_kp);
                w_mul_b = HALF_W'(w_err_abs);
            end
            S_KI: begin
                w_mul_a = MUL_A_W'(r_ki);
                w_mul_b = HALF_W'(r_period);
            end
            S_KD: begin
                w_mul_a = MUL_A_W'(r_kd);
                w_mul_b = HALF_W'(w_diff_abs);
            end
            S_ILO: begin
                w_mul_a = r_gain;
                w_mul_b = r_mag[HALF_W-1:0];
            end
            S_IHI: begin
                w_mul_a = r_gain;
                w_mul_b = r_mag[MAG_W-1:HALF_W];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);

    assign w_kp_term = r_err[ERR_W-1] ? -$signed(ACC_W'(r_mul[MUL_A_W-1:0]))
                                      : $signed(ACC_W'(r_mul[MUL_A_W-1:0]));
    assign w_isat    = (r_itot > TERM_LIMIT) ? ISAT_W'(TERM_LIMIT) : r_itot[ISAT_W-1:0];
    assign w_i_term  = r_ineg ? -$signed(ACC_W'(w_isat)) : $signed(ACC_W'(w_isat));
    assign w_quot    = (r_period == '0) ? '0 : r_dwork;
    assign w_d_term  = r_diff[DIFF_W-1] ? -$signed(ACC_W'(w_quot)) : $signed(ACC_W'(w_quot));

    always_comb begin
        w_trial = {r_drem, r_dwork[DIV_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_period});
        if (w_qbit) begin
            w_rem = PERIOD_W'(w_trial - {1'b0, r_period});
        end else begin
            w_rem = w_trial[PERIOD_W-1:0];
        end
    end

    always_comb begin
        if (r_acc > L_OUT_MAX) begin
            w_y = L_OUT_MAX;
        end else if (r_acc <= L_ZERO) begin
            w_y = L_ZERO;
        end else begin
            w_y = r_acc;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_SUM;
            end
            S_SUM:  n_state = S_KI;
            S_KI:   n_state = S_KD;
            S_KD:   n_state = S_ILO;
            S_ILO:  n_state = S_IHI;
            S_IHI:  n_state = S_IADD;
            S_IADD: n_state = S_ISAT;
            S_ISAT: n_state = S_DIV;
            S_DIV: begin
                if (r_dcnt == DIVCNT_W'(DIV_W-1)) n_state = S_FIN;
            end
            S_FIN:  n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RST;
            r_ki        <= KI_RST;
            r_kp        <= KP_RST;
            r_kd        <= KD_RST;
            r_sum       <= '0;
            r_prev_err  <= '0;
            r_int_ok    <= 1'b1;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                    REG_KI:     r_ki     <= i_cfg_wdata;
                    REG_KP:     r_kp     <= i_cfg_wdata;
                    REG_KD:     r_kd     <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_prev_err <= w_err;
            end
            if ((r_state == S_SUM) && r_int_ok) begin
                r_sum <= w_sum_sat;
            end
            if (r_state == S_ILO) begin
                r_dcnt <= '0;
            end else if (r_state == S_DIV) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_int_ok    <= (r_acc > L_ZERO) && (r_acc < L_OUT_MAX);
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= w_mul;
        if (w_accept) begin
            r_err  <= w_err;
            r_diff <= w_diff;
        end
        case (r_state)
            S_KI: begin
                r_acc <= w_kp_term;
            end
            S_KD: begin
                r_gain <= r_mul[MUL_A_W-1:0];
                r_mag  <= MAG_W'(w_sum_abs);
                r_ineg <= r_sum[SUM_WIDTH-1];
            end
            S_ILO: begin
                r_dwork <= r_mul[DIV_W-1:0];
                r_drem  <= '0;
            end
            S_IHI: begin
                r_ilo <= r_mul;
            end
            S_IADD: begin
                r_itot <= TERM_W'({r_mul, {HALF_W{1'b0}}}) + TERM_W'(r_ilo);
            end
            S_ISAT: begin
                r_acc <= r_acc + w_i_term;
            end
            S_DIV: begin
                r_dwork <= {r_dwork[DIV_W-2:0], w_qbit};
                r_drem  <= w_rem;
            end
            S_FIN: begin
                r_acc <= r_acc + w_d_term;
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_drive <= w_y[DRIVE_W-1:0];
        end
    end

    `PIDAW_ASSERT_NEXT(a_accept_starts, w_accept, r_state == S_SUM, "accepted request did not start")
    `PIDAW_ASSERT_NEXT(a_windup_hold, (r_state == S_SUM) && !r_int_ok, $stable(r_sum), "sum moved while held")
    `PIDAW_ASSERT_SAME(a_result_src, $rose(m_axis_tvalid), $past(r_state) == S_OUT, "result outside output step")

endmodule
